### rtl/fact_pkg.sv
// ----------------------------------------------------------------------------
// fact_pkg: shared constants and types for the factorial register unit
// Register offsets, fixed words, and the command/status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package fact_pkg;

	localparam int DATA_W = 32;
	localparam int OFF_W  = 8;
	localparam int CNT_W  = 6;

	localparam logic [DATA_W-1:0] ID_WORD       = 32'h0100_00ed;
	localparam logic [DATA_W-1:0] IRQ_FACT_BIT  = 32'h0000_0001;
	localparam int                STATUS_EN_BIT = 7;

	localparam logic [OFF_W-1:0] OFF_ID         = 8'h00;
	localparam logic [OFF_W-1:0] OFF_FACT       = 8'h08;
	localparam logic [OFF_W-1:0] OFF_STATUS     = 8'h20;
	localparam logic [OFF_W-1:0] OFF_INT_STATUS = 8'h24;
	localparam logic [OFF_W-1:0] OFF_INT_RAISE  = 8'h60;
	localparam logic [OFF_W-1:0] OFF_INT_ACK    = 8'h64;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// arguments from this value up give zero modulo 2^32
	localparam logic [CNT_W-1:0] FACT_ZERO_FROM = 6'd34;
	localparam logic [CNT_W-1:0] FACT_FIRST_K   = 6'd2;

	typedef struct packed {
		logic latch;   // capture the accepted access
		logic start;   // seed the multiply loop
		logic step;    // one multiply of the loop
		logic commit;  // apply the access and load the output beat
	} fact_cmd_t;

	typedef struct packed {
		logic is_long;   // held access is a factorial write needing the loop
		logic last_step; // current multiply is the final one
	} fact_sts_t;

endpackage

### rtl/fact_in_if.sv
// ----------------------------------------------------------------------------
// fact_in_if: access channel
// Valid/ready channel carrying one register access per beat.
// ----------------------------------------------------------------------------
interface fact_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  byte_offset;
	logic [31:0] write_value;

	modport source (output valid, output opcode, output byte_offset, output write_value,
		input ready);
	modport sink (input valid, input opcode, input byte_offset, input write_value,
		output ready);
endinterface

### rtl/fact_out_if.sv
// ----------------------------------------------------------------------------
// fact_out_if: response channel
// Valid/ready channel carrying read data and interrupt level per beat.
// ----------------------------------------------------------------------------
interface fact_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic        irq_level;

	modport source (output valid, output read_value, output irq_level, input ready);
	modport sink (input valid, input read_value, input irq_level, output ready);
endinterface

### rtl/fact_ctrl.sv
// ----------------------------------------------------------------------------
// fact_ctrl: sequencing controller
// Accepts an access, runs the multiply loop when needed, and hands the
// response to the output register when it is free.
// ----------------------------------------------------------------------------
module fact_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  fact_pkg::fact_sts_t sts,
	output fact_pkg::fact_cmd_t cmd
);
	import fact_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic       out_vld_q;
	logic       out_free;

	assign out_free  = !out_vld_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_long) begin
					cmd.start = 1'b1;
					state_nxt = ST_MUL;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/fact_dp.sv
// ----------------------------------------------------------------------------
// fact_dp: register file and multiply datapath
// Holds the device registers, the accepted access, the shared multiplier
// loop and the output beat register.
// ----------------------------------------------------------------------------
module fact_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fact_pkg::fact_cmd_t  cmd,
	output fact_pkg::fact_sts_t  sts,
	input  logic                 opcode,
	input  logic [7:0]           byte_offset,
	input  logic [31:0]          write_value,
	output logic [31:0]          read_value,
	output logic                 irq_level
);
	import fact_pkg::*;

	logic              op_q;
	logic [OFF_W-1:0]  off_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] acc_q;
	logic [CNT_W-1:0]  k_q;
	logic [DATA_W-1:0] fact_res_q;
	logic              irq_en_q;
	logic [DATA_W-1:0] pend_q;
	logic [DATA_W-1:0] rd_q;
	logic              irq_q;

	logic              fact_wr;
	logic              small_arg;
	logic [CNT_W-1:0]  n_lo;
	logic [DATA_W-1:0] fact_val;
	logic [DATA_W-1:0] pend_nxt;
	logic [DATA_W-1:0] rd_nxt;
	logic [DATA_W-1:0] product;

	assign fact_wr   = (op_q == OP_WRITE) && (off_q == OFF_FACT);
	assign n_lo      = val_q[CNT_W-1:0];
	assign small_arg = (val_q[DATA_W-1:CNT_W] == '0) && (n_lo < FACT_ZERO_FROM);

	assign sts.is_long   = fact_wr && small_arg && (n_lo >= FACT_FIRST_K);
	assign sts.last_step = (k_q == n_lo);

	// 0! and 1! are one, large arguments are zero, others come from the loop
	assign fact_val = sts.is_long ? acc_q : (small_arg ? 32'd1 : 32'd0);

	assign product = acc_q * {{(DATA_W-CNT_W){1'b0}}, k_q};

	always_comb begin
		pend_nxt = pend_q;
		rd_nxt   = '0;
		if (op_q == OP_WRITE) begin
			case (off_q)
				OFF_FACT:      if (irq_en_q) pend_nxt = pend_q | IRQ_FACT_BIT;
				OFF_INT_RAISE: pend_nxt = pend_q | val_q;
				OFF_INT_ACK:   pend_nxt = pend_q & ~val_q;
				default:       pend_nxt = pend_q;
			endcase
		end else begin
			case (off_q)
				OFF_ID:         rd_nxt = ID_WORD;
				OFF_FACT:       rd_nxt = fact_res_q;
				OFF_STATUS:     rd_nxt = {{(DATA_W-1){1'b0}}, irq_en_q} << STATUS_EN_BIT;
				OFF_INT_STATUS: rd_nxt = pend_q;
				default:        rd_nxt = '0;
			endcase
		end
	end

	// access capture, loop and output beat: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= opcode;
			off_q <= byte_offset;
			val_q <= write_value;
		end
		if (cmd.start) begin
			acc_q <= 32'd1;
			k_q   <= FACT_FIRST_K;
		end else if (cmd.step) begin
			acc_q <= product;
			k_q   <= k_q + 1'b1;
		end
		if (cmd.commit) begin
			rd_q  <= rd_nxt;
			irq_q <= (pend_nxt != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fact_res_q <= '0;
			irq_en_q   <= 1'b0;
			pend_q     <= '0;
		end else if (cmd.commit) begin
			pend_q <= pend_nxt;
			if (fact_wr) begin
				fact_res_q <= fact_val;
			end
			if ((op_q == OP_WRITE) && (off_q == OFF_STATUS)) begin
				irq_en_q <= val_q[STATUS_EN_BIT];
			end
		end
	end

	assign read_value = rd_q;
	assign irq_level  = irq_q;

endmodule

### rtl/factorial_unit_with_interrupt_regs.sv
// ----------------------------------------------------------------------------
// factorial_unit_with_interrupt_regs: factorial device with interrupt regs
// Sequence: an access is captured and then committed to the output register;
//   a factorial write of n in 2..33 first runs the loop, one multiply per cycle,
//   n-1 in all, on the shared 32x6 multiplier. Accesses are taken one at a
//   time, a new one only after the last is committed. A stalled response
//   holds the controller until the output register frees.
// Reset: arst_n clears the result, enable and pending registers and idles.
// ----------------------------------------------------------------------------
module factorial_unit_with_interrupt_regs (
	input  logic       clk,
	input  logic       arst_n,
	fact_in_if.sink    in_ch,
	fact_out_if.source out_ch
);
	import fact_pkg::*;

	// command and status between sequencer and datapath
	fact_cmd_t cmd;
	fact_sts_t sts;

	// Controller: takes one access at a time. It captures the beat, decides
	// whether the multiply loop must run, steps it, and then commits the
	// access once the output register is free to take the response.
	fact_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: device registers, one multiplier shared across the loop,
	// and the output beat register that holds the response until taken.
	fact_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (in_ch.opcode),
		.byte_offset (in_ch.byte_offset),
		.write_value (in_ch.write_value),
		.read_value  (out_ch.read_value),
		.irq_level   (out_ch.irq_level)
	);

endmodule
